>>> hdl/stsd_pkg.sv
// Package for the scaled timestamp decoder.
// Holds field widths, request codes and the controller/datapath command and status types.
`default_nettype none

package stsd_pkg;

  localparam int STSD_TS_WIDTH = 32;
  localparam int REQ_W = 3;
  localparam int VAL_W = 32;
  localparam int K_W = 6;
  localparam int SN_W = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_RECORD   = 3'd0,
    REQ_SCALED   = 3'd1,
    REQ_UNSCALED = 3'd2,
    REQ_DEDUCE   = 3'd3,
    REQ_COMMIT   = 3'd4
  } req_e;

  typedef struct packed {
    logic load;
    logic set_stride;
    logic set_low;
    logic win;
    logic set_ded;
    logic mstep;
    logic dstart;
    logic dstep;
    logic fin;
    logic commit;
    logic res_val;
    logic res_fail;
    logic emit;
  } stsd_cmd_t;

  typedef struct packed {
    req_e req;
    logic k_bad;
    logic eff_zero;
    logic last;
    logic out_busy;
  } stsd_stat_t;

endpackage

`default_nettype wire

>>> hdl/stsd_ctrl.sv
// Controller for the scaled timestamp decoder.
// One-hot sequencer that issues stsd_cmd_t commands to stsd_dp; uses stsd_pkg.
`default_nettype none

module stsd_ctrl
  import stsd_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  stsd_stat_t stat_i,
  output stsd_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DISP = 6'b000010,
    S_WIN  = 6'b000100,
    S_MUL  = 6'b001000,
    S_DIV  = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (stat_i.req)
          REQ_RECORD: begin
            cmd_o.set_stride = 1'b1;
            state_d = S_FIN;
          end
          REQ_SCALED: begin
            if (stat_i.k_bad) begin
              cmd_o.res_fail = 1'b1;
              state_d = S_FIN;
            end else begin
              cmd_o.set_low = 1'b1;
              state_d = S_WIN;
            end
          end
          REQ_UNSCALED: begin
            if (stat_i.eff_zero) begin
              cmd_o.res_val = 1'b1;
              state_d = S_FIN;
            end else begin
              cmd_o.dstart = 1'b1;
              state_d = S_DIV;
            end
          end
          REQ_DEDUCE: begin
            cmd_o.set_ded = 1'b1;
            state_d = S_MUL;
          end
          REQ_COMMIT: begin
            cmd_o.commit = 1'b1;
            state_d = S_FIN;
          end
          default: begin
            cmd_o.res_fail = 1'b1;
            state_d = S_FIN;
          end
        endcase
      end
      S_WIN: begin
        cmd_o.win = 1'b1;
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mstep = 1'b1;
        cmd_o.fin = stat_i.last;
        if (stat_i.last) begin
          state_d = S_FIN;
        end
      end
      S_DIV: begin
        cmd_o.dstep = 1'b1;
        cmd_o.fin = stat_i.last;
        if (stat_i.last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTH
  a_accept_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == S_DISP)
    else $error("accepted word did not enter dispatch");
  a_win_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WIN |=> state_q == S_MUL && $past(stat_i.req) == REQ_SCALED)
    else $error("window step out of sequence");
`endif

endmodule

`default_nettype wire

>>> hdl/stsd_dp.sv
// Datapath for the scaled timestamp decoder: context registers, LSB window,
// shift-add multiplier, restoring divider and output register. Uses stsd_pkg.
`default_nettype none

module stsd_dp
  import stsd_pkg::*;
#(
  parameter int TS_WIDTH = STSD_TS_WIDTH
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire [REQ_W-1:0]   req_type_i,
  input  wire [VAL_W-1:0]   value_word_i,
  input  wire [K_W-1:0]     bits_count_i,
  input  wire [SN_W-1:0]    seq_num_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic [VAL_W-1:0]  timestamp_o,
  output logic              ok_o,
  input  stsd_cmd_t         cmd_i,
  output stsd_stat_t        stat_o
);

  localparam int W = TS_WIDTH;
  localparam int CW = $clog2(TS_WIDTH);
  localparam int KCW = K_W + 1;

  logic [W-1:0] stride_c_q, stride_c_d, scaled_c_q, scaled_c_d, offset_c_q, offset_c_d;
  logic [W-1:0] stride_p_q, stride_p_d, scaled_p_q, scaled_p_d, offset_p_q, offset_p_d;
  logic [SN_W-1:0] seq_c_q, seq_c_d;

  req_e            req_q, req_d;
  logic [W-1:0]    val_q, val_d;
  logic [K_W-1:0]  k_q, k_d;
  logic [SN_W-1:0] sn_q, sn_d;

  logic [W-1:0]  a_q, a_d, b_q, b_d, acc_q, acc_d, sc_q, sc_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  res_q, res_d;
  logic          rok_q, rok_d;

  logic              out_valid_q, out_valid_d;
  logic [VAL_W-1:0]  out_ts_q, out_ts_d;
  logic              out_ok_q, out_ok_d;

  logic [W+VAL_W-1:0] val_ext, res_ext;
  logic [W-1:0]       val_in, one, eff, mask, pwin, low, win_sc, ded_sc;
  logic [W-1:0]       mul_acc;
  logic [W:0]         rem_sh, diff;
  logic               take;
  logic [W-1:0]       div_rem, div_quo;

  assign val_ext = {{W{1'b0}}, value_word_i};
  assign val_in  = val_ext[W-1:0];
  assign res_ext = {{VAL_W{1'b0}}, res_q};
  assign one     = W'(1);

  assign eff  = (stride_p_q != '0) ? stride_p_q : stride_c_q;
  assign mask = (one << k_q) - one;
  assign pwin = (k_q <= K_W'(2)) ? '0 : ((one << (k_q - K_W'(2))) - one);
  assign low  = scaled_c_q - pwin;
  assign win_sc = a_q + ((val_q - a_q) & b_q);
  assign ded_sc = scaled_c_q + W'(sn_q) - W'(seq_c_q);

  assign mul_acc = b_q[0] ? (acc_q + a_q) : acc_q;

  assign rem_sh  = {acc_q, a_q[W-1]};
  assign diff    = rem_sh - {1'b0, b_q};
  assign take    = !diff[W];
  assign div_rem = take ? diff[W-1:0] : rem_sh[W-1:0];
  assign div_quo = {a_q[W-2:0], take};

  assign stat_o.req      = req_q;
  assign stat_o.k_bad    = (k_q == '0) || ({1'b0, k_q} > KCW'(W));
  assign stat_o.eff_zero = (eff == '0);
  assign stat_o.last     = (cnt_q == CW'(W - 1));
  assign stat_o.out_busy = out_valid_q && out_stall_i;

  always_comb begin
    stride_c_d = stride_c_q;
    scaled_c_d = scaled_c_q;
    offset_c_d = offset_c_q;
    seq_c_d    = seq_c_q;
    stride_p_d = stride_p_q;
    scaled_p_d = scaled_p_q;
    offset_p_d = offset_p_q;
    req_d = req_q;
    val_d = val_q;
    k_d   = k_q;
    sn_d  = sn_q;
    a_d   = a_q;
    b_d   = b_q;
    acc_d = acc_q;
    sc_d  = sc_q;
    cnt_d = cnt_q;
    res_d = res_q;
    rok_d = rok_q;

    if (cmd_i.load) begin
      req_d = req_e'(req_type_i);
      val_d = val_in;
      k_d   = bits_count_i;
      sn_d  = seq_num_i;
    end
    if (cmd_i.set_stride) begin
      stride_p_d = val_q;
      res_d = '0;
      rok_d = 1'b1;
    end
    if (cmd_i.res_fail) begin
      res_d = '0;
      rok_d = 1'b0;
    end
    if (cmd_i.res_val) begin
      res_d = val_q;
      rok_d = 1'b1;
    end
    if (cmd_i.set_low) begin
      a_d = low;
      b_d = mask;
    end
    if (cmd_i.win || cmd_i.set_ded) begin
      sc_d  = cmd_i.win ? win_sc : ded_sc;
      a_d   = sc_d;
      b_d   = stride_c_q;
      acc_d = offset_c_q;
      cnt_d = '0;
    end
    if (cmd_i.mstep) begin
      acc_d = mul_acc;
      a_d   = a_q << 1;
      b_d   = b_q >> 1;
      cnt_d = cnt_q + CW'(1);
      if (cmd_i.fin) begin
        res_d = mul_acc;
        rok_d = 1'b1;
        scaled_p_d = sc_q;
        stride_p_d = stride_c_q;
        offset_p_d = offset_c_q;
      end
    end
    if (cmd_i.dstart) begin
      a_d   = val_q;
      b_d   = eff;
      acc_d = '0;
      cnt_d = '0;
    end
    if (cmd_i.dstep) begin
      acc_d = div_rem;
      a_d   = div_quo;
      cnt_d = cnt_q + CW'(1);
      if (cmd_i.fin) begin
        res_d = val_q;
        rok_d = 1'b1;
        scaled_p_d = div_quo;
        offset_p_d = div_rem;
        stride_p_d = b_q;
      end
    end
    if (cmd_i.commit) begin
      seq_c_d    = sn_q;
      scaled_c_d = scaled_p_q;
      stride_c_d = stride_p_q;
      offset_c_d = offset_p_q;
      scaled_p_d = '0;
      stride_p_d = '0;
      offset_p_d = '0;
      res_d = val_q;
      rok_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_ts_d    = out_ts_q;
    out_ok_d    = out_ok_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_ts_d    = res_ext[VAL_W-1:0];
      out_ok_d    = rok_q;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign timestamp_o = out_ts_q;
  assign ok_o        = out_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_c_q  <= '0;
      scaled_c_q  <= '0;
      offset_c_q  <= '0;
      seq_c_q     <= '0;
      stride_p_q  <= '0;
      scaled_p_q  <= '0;
      offset_p_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      stride_c_q  <= stride_c_d;
      scaled_c_q  <= scaled_c_d;
      offset_c_q  <= offset_c_d;
      seq_c_q     <= seq_c_d;
      stride_p_q  <= stride_p_d;
      scaled_p_q  <= scaled_p_d;
      offset_p_q  <= offset_p_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    val_q    <= val_d;
    k_q      <= k_d;
    sn_q     <= sn_d;
    a_q      <= a_d;
    b_q      <= b_d;
    acc_q    <= acc_d;
    sc_q     <= sc_d;
    cnt_q    <= cnt_d;
    res_q    <= res_d;
    rok_q    <= rok_d;
    out_ts_q <= out_ts_d;
    out_ok_q <= out_ok_d;
  end

`ifndef SYNTH
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !(out_valid_q && out_stall_i))
    else $error("result written over a stalled word");
  a_commit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> stride_p_q == '0 && scaled_p_q == '0 && offset_p_q == '0)
    else $error("pending set not cleared by commit");
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.dstep |-> b_q != '0)
    else $error("divide step with zero stride");
  a_commit_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> seq_c_q == $past(sn_q))
    else $error("sequence number not committed");
`endif

endmodule

`default_nettype wire

>>> hdl/scaled_timestamp_decoder.sv
// Scaled timestamp decoder, top level.
// Input channel: in_valid_i / in_stall_o carry one request word (req_type_i,
//   value_word_i, bits_count_i, seq_num_i). Output channel: out_valid_o /
//   out_stall_i carry one result word (timestamp_o, ok_o) per request.
// A word moves when valid is high and stall is low at a rising clock edge.
// Record stride, commit, unknown requests, failed LSB decodes and unscaled
//   requests with zero stride go from dispatch straight to the result. Decode
//   scaled passes a window step and the multiplier, deduce from SN the
//   multiplier, and decode unscaled with a stride the divider: the shift-add
//   multiplier and the restoring divider retire one bit per cycle.
// One request is in work at a time; in_stall_o is high from accept until the
//   result is written into the output register, so the next request waits
//   behind a multiply or divide until that result is written.
// The output register holds a result while out_stall_i is high; a new request
//   can be accepted meanwhile, and its result waits until the register frees.
// Reset clears the committed and pending context to zero and empties the
//   output register.
// Uses stsd_pkg, stsd_ctrl and stsd_dp.
`default_nettype none

module scaled_timestamp_decoder
  import stsd_pkg::*;
#(
  parameter int TS_WIDTH = STSD_TS_WIDTH
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_stall_o,
  input  wire [REQ_W-1:0]  req_type_i,
  input  wire [VAL_W-1:0]  value_word_i,
  input  wire [K_W-1:0]    bits_count_i,
  input  wire [SN_W-1:0]   seq_num_i,
  output logic             out_valid_o,
  input  wire              out_stall_i,
  output logic [VAL_W-1:0] timestamp_o,
  output logic             ok_o
);

  stsd_cmd_t  cmd;
  stsd_stat_t stat;

  stsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  stsd_dp #(
    .TS_WIDTH (TS_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_type_i   (req_type_i),
    .value_word_i (value_word_i),
    .bits_count_i (bits_count_i),
    .seq_num_i    (seq_num_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .timestamp_o  (timestamp_o),
    .ok_o         (ok_o),
    .cmd_i        (cmd),
    .stat_o       (stat)
  );

endmodule

`default_nettype wire

>>> test/scaled_timestamp_decoder_test.sv
// Self-checking bench for scaled_timestamp_decoder: directed and random request words,
// with bursty input, a stall pattern on the output, and an in-bench predictor of the context.
// Depends on stsd_pkg and the scaled_timestamp_decoder top level only.
`timescale 1ns / 1ps

module scaled_timestamp_decoder_test;
  import stsd_pkg::*;

  localparam int                IDLE_LIMIT    = 4000;
  localparam int                RANDOM_WORDS  = 450;
  localparam int                SETTLE_CYCLES = 50;
  localparam logic [REQ_W-1:0]  REQ_BAD_FIRST = 3'd5;
  localparam logic [REQ_W-1:0]  REQ_BAD_LAST  = 3'd7;

  typedef struct {
    logic [REQ_W-1:0] req;
    logic [VAL_W-1:0] value;
    logic [K_W-1:0]   k;
    logic [SN_W-1:0]  sn;
    bit               drain_first;
  } ts_request_t;

  typedef struct {
    logic [VAL_W-1:0] ts;
    logic             ok;
  } ts_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [REQ_W-1:0] req_type = '0;
  logic [VAL_W-1:0] value_word = '0;
  logic [K_W-1:0]   bits_count = '0;
  logic [SN_W-1:0]  seq_num = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [VAL_W-1:0] timestamp;
  logic             ok;

  scaled_timestamp_decoder dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .req_type_i   (req_type),
    .value_word_i (value_word),
    .bits_count_i (bits_count),
    .seq_num_i    (seq_num),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .timestamp_o  (timestamp),
    .ok_o         (ok)
  );

  always #2 clk = ~clk;

  ts_request_t request_q[$];
  ts_result_t  expected_ts_q[$];

  logic [VAL_W-1:0] ctx_stride, ctx_scaled, ctx_offset;
  logic [SN_W-1:0]  ctx_seq;
  logic [VAL_W-1:0] pend_stride, pend_scaled, pend_offset;

  int err_count = 0;
  int words_in = 0;
  int words_out = 0;
  int failed_decodes = 0;
  int unknown_reqs = 0;
  int drain_pauses = 0;
  int idle_cycles = 0;
  int burst_left = 4;
  int gap_left = 0;
  int stall_left = 0;
  int stall_kind = 0;
  bit in_taken = 1'b0;

  task automatic decode_timestamp(input ts_request_t rq, output ts_result_t rs);
    logic [VAL_W-1:0] sc, p, kmask, low, eff;
    rs.ts = '0;
    rs.ok = 1'b1;
    case (rq.req)
      REQ_RECORD: begin
        pend_stride = rq.value;
      end
      REQ_SCALED: begin
        if (rq.k == 0 || rq.k > STSD_TS_WIDTH) begin
          rs.ok = 1'b0;
        end else begin
          if (rq.k == STSD_TS_WIDTH) begin
            sc = rq.value;
          end else begin
            p = (rq.k <= 2) ? '0 : (32'd1 << (rq.k - 2)) - 1;
            kmask = (32'd1 << rq.k) - 1;
            low = ctx_scaled - p;
            sc = low + (((rq.value & kmask) - low) & kmask);
          end
          rs.ts = ctx_stride * sc + ctx_offset;
          pend_scaled = sc;
          pend_stride = ctx_stride;
          pend_offset = ctx_offset;
        end
      end
      REQ_UNSCALED: begin
        eff = (pend_stride != 0) ? pend_stride : ctx_stride;
        if (eff != 0) begin
          pend_offset = rq.value % eff;
          pend_scaled = rq.value / eff;
          pend_stride = eff;
        end
        rs.ts = rq.value;
      end
      REQ_DEDUCE: begin
        sc = ctx_scaled + 32'(rq.sn) - 32'(ctx_seq);
        rs.ts = sc * ctx_stride + ctx_offset;
        pend_scaled = sc;
        pend_stride = ctx_stride;
        pend_offset = ctx_offset;
      end
      REQ_COMMIT: begin
        ctx_seq = rq.sn;
        ctx_scaled = pend_scaled;
        ctx_stride = pend_stride;
        ctx_offset = pend_offset;
        pend_scaled = '0;
        pend_stride = '0;
        pend_offset = '0;
        rs.ts = rq.value;
      end
      default: begin
        rs.ok = 1'b0;
      end
    endcase
  endtask

  task automatic push_req(input logic [REQ_W-1:0] req, input logic [VAL_W-1:0] value,
                          input logic [K_W-1:0] k, input logic [SN_W-1:0] sn,
                          input bit drain_first = 1'b0);
    ts_request_t rq;
    rq.req = req;
    rq.value = value;
    rq.k = k;
    rq.sn = sn;
    rq.drain_first = drain_first;
    request_q.push_back(rq);
  endtask

  function automatic logic [VAL_W-1:0] pick_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_stride();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return $urandom;
      2: return '1;
      default: return $urandom_range(1, 1000);
    endcase
  endfunction

  // Monitor and predictor: both channels sampled at the rising edge.
  always @(posedge clk) begin : monitor
    ts_request_t rq;
    ts_result_t  rs, want;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        rq.req = req_type;
        rq.value = value_word;
        rq.k = bits_count;
        rq.sn = seq_num;
        rq.drain_first = 1'b0;
        decode_timestamp(rq, rs);
        expected_ts_q.push_back(rs);
        words_in++;
        if (rq.req >= REQ_BAD_FIRST) unknown_reqs++;
        else if (!rs.ok) failed_decodes++;
      end
      if (out_valid && !out_stall) begin
        words_out++;
        if (expected_ts_q.size() == 0) begin
          $error("unexpected result word: timestamp=%h ok=%b", timestamp, ok);
          err_count++;
        end else begin
          want = expected_ts_q.pop_front();
          if (timestamp !== want.ts) begin
            $error("timestamp: expected %h, got %h", want.ts, timestamp);
            err_count++;
          end
          if (ok !== want.ok) begin
            $error("ok: expected %b, got %b", want.ok, ok);
            err_count++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
          $display("[scaled_timestamp_decoder] ERROR");
          $finish;
        end
      end
    end
  end

  // Driver: bursts with random gaps; hold a word until it is taken.
  always @(negedge clk) begin : driver
    ts_request_t rq;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (request_q.size() == 0 ||
                   (request_q[0].drain_first && expected_ts_q.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        rq = request_q.pop_front();
        if (rq.drain_first) drain_pauses++;
        req_type <= rq.req;
        value_word <= rq.value;
        bits_count <= rq.k;
        seq_num <= rq.sn;
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(0, 6);
        end
      end
    end
  end

  // Receiver stall: segments of no stall, random stall, or a solid streak.
  always @(negedge clk) begin : stall_gen
    if (stall_left == 0) begin
      stall_kind = $urandom_range(0, 2);
      stall_left = (stall_kind == 2) ? $urandom_range(1, 20) : $urandom_range(10, 80);
    end
    stall_left--;
    case (stall_kind)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= 1'b1;
    endcase
  end

  initial begin : stimulus
    int               n_random;
    int               op;
    logic [SN_W-1:0]  gen_sn;
    logic [K_W-1:0]   k;
    ctx_stride = '0;
    ctx_scaled = '0;
    ctx_offset = '0;
    ctx_seq = '0;
    pend_stride = '0;
    pend_scaled = '0;
    pend_offset = '0;
    n_random = 0;
    gen_sn = '0;

    // directed: empty commit, bad k, unknown codes, zero stride
    push_req(REQ_COMMIT, '0, '0, '0);
    push_req(REQ_SCALED, '1, 6'd0, '0);
    push_req(REQ_SCALED, '0, 6'd33, '0);
    push_req(REQ_SCALED, '1, '1, '1);
    for (int c = REQ_BAD_FIRST; c <= REQ_BAD_LAST; c++) push_req(3'(c), '1, '1, '1);
    push_req(REQ_UNSCALED, '1, '0, '0);
    push_req(REQ_DEDUCE, '0, '0, '1);
    // build a committed context, then decode at the k extremes
    push_req(REQ_RECORD, 32'd160, '0, '0, 1'b1);
    push_req(REQ_UNSCALED, 32'd1000123, '0, '0);
    push_req(REQ_COMMIT, 32'd1000123, '0, '0);
    push_req(REQ_SCALED, '1, 6'd1, '0);
    push_req(REQ_SCALED, '0, 6'd2, '0);
    push_req(REQ_SCALED, '1, 6'd3, '0);
    push_req(REQ_SCALED, '1, 6'd31, '0);
    push_req(REQ_SCALED, '0, 6'd32, '0);
    // largest forward and backward SN differences
    push_req(REQ_DEDUCE, '0, '0, '1);
    push_req(REQ_COMMIT, 32'hdead_beef, '0, '1);
    push_req(REQ_DEDUCE, '0, '0, '0);
    // full-width stride and divide
    push_req(REQ_RECORD, '1, '0, '0);
    push_req(REQ_UNSCALED, '1, '0, '0);
    push_req(REQ_COMMIT, '1, '0, 16'h1234);
    // commit without decode, then unscaled on the committed stride
    push_req(REQ_RECORD, 32'd7, '0, '0);
    push_req(REQ_COMMIT, 32'd42, '0, 16'd5);
    push_req(REQ_UNSCALED, 32'd1000, '0, '0);

    while (n_random < RANDOM_WORDS) begin
      if ($urandom_range(0, 99) < 75) begin
        if ($urandom_range(0, 2) == 0) begin
          push_req(REQ_RECORD, pick_stride(), '0, '0, $urandom_range(0, 49) == 0);
          n_random++;
        end
        op = $urandom_range(0, 2);
        if (op == 0) begin
          k = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(1, 32));
          push_req(REQ_SCALED, pick_word(), k, 16'($urandom_range(0, 65535)));
        end else if (op == 1) begin
          push_req(REQ_UNSCALED, pick_word(), 6'($urandom_range(0, 63)),
                   16'($urandom_range(0, 65535)));
        end else begin
          push_req(REQ_DEDUCE, $urandom, 6'($urandom_range(0, 63)),
                   ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                               : gen_sn + 16'($urandom_range(0, 40)) - 16'd10);
        end
        gen_sn = gen_sn + 16'($urandom_range(1, 20));
        push_req(REQ_COMMIT, pick_word(), 6'($urandom_range(0, 63)), gen_sn);
        n_random += 2;
      end else begin
        push_req(3'($urandom_range(0, 7)), $urandom, 6'($urandom_range(0, 63)),
                 16'($urandom_range(0, 65535)), $urandom_range(0, 49) == 0);
        n_random++;
      end
    end

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_ts_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d requests and %0d results: %0d failed LSB decodes, %0d unknown codes,",
             words_in, words_out, failed_decodes, unknown_reqs);
    $display("%0d pauses until the pipe drained, with bursty input and output stalls",
             drain_pauses);
    if (err_count == 0 && expected_ts_q.size() == 0) begin
      $display("[scaled_timestamp_decoder] OK");
    end else begin
      $display("[scaled_timestamp_decoder] ERROR");
    end
    $finish;
  end

endmodule
